@@ rtl/core/huffman_weight_priority_queue_top_macros.svh @@
// assertion helpers used by the rtl top
`ifndef HUFFMAN_WEIGHT_PRIORITY_QUEUE_TOP_MACROS_SVH
`define HUFFMAN_WEIGHT_PRIORITY_QUEUE_TOP_MACROS_SVH

// property that must hold on every clock edge out of reset
`define HWPQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HWPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hwpq_pkg.sv @@
package hwpq_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TAG_W    = 9;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned DEF_QUEUE_DEPTH = 256;
  localparam int unsigned DEF_WEIGHT_BITS = 32;

  localparam logic [TAG_W-1:0] FIRST_INTERNAL_TAG = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_MERGE  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_DONE   = 3'd3,
    STAT_ZERO   = 3'd4
  } status_e;

  // what every cell of the row does at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_POP   = 2'd2,
    CELL_MRG   = 2'd3
  } cell_op_e;

endpackage

@@ rtl/core/hwpq_if.sv @@
interface hwpq_in_if;
  logic                             valid;
  logic                             ready;
  logic [hwpq_pkg::KIND_W-1:0]      kind;
  logic [hwpq_pkg::TAG_W-1:0]       tag;
  logic [hwpq_pkg::WEIGHT_W-1:0]    weight;

  modport source (output valid, kind, tag, weight, input ready);
  modport sink   (input valid, kind, tag, weight, output ready);
endinterface

interface hwpq_out_if;
  logic                             valid;
  logic                             ready;
  logic [hwpq_pkg::STATUS_W-1:0]    status;
  logic [hwpq_pkg::TAG_W-1:0]       first_tag;
  logic [hwpq_pkg::WEIGHT_W-1:0]    first_weight;
  logic [hwpq_pkg::TAG_W-1:0]       second_tag;
  logic [hwpq_pkg::WEIGHT_W-1:0]    second_weight;
  logic [hwpq_pkg::TAG_W-1:0]       merged_tag;
  logic [hwpq_pkg::WEIGHT_W-1:0]    merged_weight;

  modport source (output valid, status, first_tag, first_weight, second_tag,
                  second_weight, merged_tag, merged_weight, input ready);
  modport sink   (input valid, status, first_tag, first_weight, second_tag,
                  second_weight, merged_tag, merged_weight, output ready);
endinterface

@@ rtl/core/huffman_weight_priority_queue_top.sv @@
// insert and pop: result registered at the accept edge, one beat per cycle while
//   res_o is ready; merge: result registered at the accept edge, then the cell row
//   drops both children and inserts the new node in ST_MERGE, taking no request
// the rate is set by the single compare-and-shift move of the cell row per cycle
// reset clears the entry count, the internal tag counter (to 256) and the handshake
module huffman_weight_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = hwpq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WEIGHT_BITS = hwpq_pkg::DEF_WEIGHT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hwpq_in_if.sink     req_i,
  hwpq_out_if.source  res_o
);

  `include "huffman_weight_priority_queue_top_macros.svh"

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WIDE_W =
    (WEIGHT_BITS > hwpq_pkg::WEIGHT_W) ? WEIGHT_BITS : hwpq_pkg::WEIGHT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_e;

  function automatic logic [hwpq_pkg::WEIGHT_W-1:0] to_field(
    input logic [WEIGHT_BITS-1:0] x
  );
    logic [WIDE_W-1:0] e;
    e = WIDE_W'(x);
    return e[hwpq_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] from_field(
    input logic [hwpq_pkg::WEIGHT_W-1:0] x
  );
    logic [WIDE_W-1:0] e;
    e = WIDE_W'(x);
    return e[WEIGHT_BITS-1:0];
  endfunction

  state_e                       state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [hwpq_pkg::TAG_W-1:0]   next_tag_q, next_tag_d;
  logic [hwpq_pkg::TAG_W-1:0]   key_tag_q, key_tag_d;
  logic [WEIGHT_BITS-1:0]       key_weight_q, key_weight_d;

  logic                         out_valid_q, out_valid_d;
  logic [hwpq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [hwpq_pkg::TAG_W-1:0]   first_tag_q, first_tag_d;
  logic [hwpq_pkg::WEIGHT_W-1:0] first_weight_q, first_weight_d;
  logic [hwpq_pkg::TAG_W-1:0]   second_tag_q, second_tag_d;
  logic [hwpq_pkg::WEIGHT_W-1:0] second_weight_q, second_weight_d;
  logic [hwpq_pkg::TAG_W-1:0]   merged_tag_q, merged_tag_d;
  logic [hwpq_pkg::WEIGHT_W-1:0] merged_weight_q, merged_weight_d;

  logic                         accept;
  logic [WEIGHT_BITS-1:0]       in_weight;
  logic [hwpq_pkg::TAG_W-1:0]   h0_tag, h1_tag;
  logic [WEIGHT_BITS-1:0]       h0_weight, h1_weight;
  logic [WEIGHT_BITS:0]         sum_full;
  logic [WEIGHT_BITS-1:0]       sum_sat;
  hwpq_pkg::cell_op_e           cell_op;
  logic [hwpq_pkg::TAG_W-1:0]   chain_tag;
  logic [WEIGHT_BITS-1:0]       chain_weight;
  logic                         ins_ok;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign in_weight   = from_field(req_i.weight);

  assign sum_full = {1'b0, h0_weight} + {1'b0, h1_weight};
  assign sum_sat  = sum_full[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}} : sum_full[WEIGHT_BITS-1:0];

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    next_tag_d      = next_tag_q;
    key_tag_d       = key_tag_q;
    key_weight_d    = key_weight_q;
    cell_op         = hwpq_pkg::CELL_HOLD;
    ins_ok          = 1'b0;
    out_valid_d     = out_valid_q && !res_o.ready;
    status_d        = status_q;
    first_tag_d     = first_tag_q;
    first_weight_d  = first_weight_q;
    second_tag_d    = second_tag_q;
    second_weight_d = second_weight_q;
    merged_tag_d    = merged_tag_q;
    merged_weight_d = merged_weight_q;

    if (state_q == ST_MERGE) begin
      cell_op = hwpq_pkg::CELL_MRG;
      count_d = count_q - 1'b1;
      state_d = ST_IDLE;
    end else if (accept) begin
      out_valid_d     = 1'b1;
      status_d        = hwpq_pkg::STAT_EMPTY;
      first_tag_d     = '0;
      first_weight_d  = '0;
      second_tag_d    = '0;
      second_weight_d = '0;
      merged_tag_d    = '0;
      merged_weight_d = '0;
      case (req_i.kind)
        hwpq_pkg::KIND_INSERT: begin
          if (in_weight == '0) begin
            status_d = hwpq_pkg::STAT_ZERO;
          end else if (count_q == FULL_CNT) begin
            status_d = hwpq_pkg::STAT_FULL;
          end else begin
            status_d = hwpq_pkg::STAT_OK;
            cell_op  = hwpq_pkg::CELL_INS;
            count_d  = count_q + 1'b1;
            ins_ok   = 1'b1;
          end
        end
        hwpq_pkg::KIND_POP: begin
          if (count_q != '0) begin
            status_d       = hwpq_pkg::STAT_OK;
            first_tag_d    = h0_tag;
            first_weight_d = to_field(h0_weight);
            cell_op        = hwpq_pkg::CELL_POP;
            count_d        = count_q - 1'b1;
          end
        end
        hwpq_pkg::KIND_MERGE: begin
          if (count_q == CNT_W'(1)) begin
            status_d       = hwpq_pkg::STAT_DONE;
            first_tag_d    = h0_tag;
            first_weight_d = to_field(h0_weight);
          end else if (count_q != '0) begin
            status_d        = hwpq_pkg::STAT_OK;
            first_tag_d     = h0_tag;
            first_weight_d  = to_field(h0_weight);
            second_tag_d    = h1_tag;
            second_weight_d = to_field(h1_weight);
            merged_tag_d    = next_tag_q;
            merged_weight_d = to_field(sum_sat);
            key_tag_d       = next_tag_q;
            key_weight_d    = sum_sat;
            next_tag_d      = next_tag_q + 1'b1;
            state_d         = ST_MERGE;
          end
        end
        default: begin
          status_d = hwpq_pkg::STAT_EMPTY;
        end
      endcase
    end
  end

  assign chain_tag    = (state_q == ST_MERGE) ? key_tag_q : req_i.tag;
  assign chain_weight = (state_q == ST_MERGE) ? key_weight_q : in_weight;

  hwpq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk_i          (clk_i),
    .op_i           (cell_op),
    .count_i        (count_q),
    .key_tag_i      (chain_tag),
    .key_weight_i   (chain_weight),
    .head0_tag_o    (h0_tag),
    .head0_weight_o (h0_weight),
    .head1_tag_o    (h1_tag),
    .head1_weight_o (h1_weight)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_tag_q  <= hwpq_pkg::FIRST_INTERNAL_TAG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_tag_q  <= next_tag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_tag_q       <= key_tag_d;
    key_weight_q    <= key_weight_d;
    status_q        <= status_d;
    first_tag_q     <= first_tag_d;
    first_weight_q  <= first_weight_d;
    second_tag_q    <= second_tag_d;
    second_weight_q <= second_weight_d;
    merged_tag_q    <= merged_tag_d;
    merged_weight_q <= merged_weight_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = status_q;
  assign res_o.first_tag     = first_tag_q;
  assign res_o.first_weight  = first_weight_q;
  assign res_o.second_tag    = second_tag_q;
  assign res_o.second_weight = second_weight_q;
  assign res_o.merged_tag    = merged_tag_q;
  assign res_o.merged_weight = merged_weight_q;

  `HWPQ_ASSERT_NEXT(a_merge_one_cycle, state_q == ST_MERGE, state_q == ST_IDLE,
    "merge finish lasted more than one cycle")
  `HWPQ_ASSERT(a_no_accept_in_merge, !(state_q == ST_MERGE && req_i.ready),
    "input taken while the cell row finishes a merge")
  `HWPQ_ASSERT(a_count_bound, count_q <= FULL_CNT, "entry count above queue depth")
  `HWPQ_ASSERT_NEXT(a_insert_count, ins_ok, count_q == $past(count_q) + 1'b1,
    "accepted insert did not grow the queue")

endmodule

@@ rtl/core/hwpq_cell.sv @@
module hwpq_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned WEIGHT_BITS = hwpq_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                        clk_i,
  input  hwpq_pkg::cell_op_e          op_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [hwpq_pkg::TAG_W-1:0]  key_tag_i,
  input  logic [WEIGHT_BITS-1:0]      key_weight_i,
  input  logic [hwpq_pkg::TAG_W-1:0]  left_tag_i,
  input  logic [WEIGHT_BITS-1:0]      left_weight_i,
  input  logic                        left_ge_i,
  input  logic [hwpq_pkg::TAG_W-1:0]  r1_tag_i,
  input  logic [WEIGHT_BITS-1:0]      r1_weight_i,
  input  logic                        r1_ge_i,
  input  logic [hwpq_pkg::TAG_W-1:0]  r2_tag_i,
  input  logic [WEIGHT_BITS-1:0]      r2_weight_i,
  input  logic                        r2_lt_i,
  output logic [hwpq_pkg::TAG_W-1:0]  tag_o,
  output logic [WEIGHT_BITS-1:0]      weight_o,
  output logic                        ge_o,
  output logic                        lt_o
);

  logic [hwpq_pkg::TAG_W-1:0] tag_q, tag_d;
  logic [WEIGHT_BITS-1:0]     weight_q, weight_d;
  logic                       occ;
  logic                       below;

  assign occ   = CNT_W'(IDX) < count_i;
  assign below = weight_q < key_weight_i;
  assign lt_o  = occ && below;
  assign ge_o  = occ && !below;

  always_comb begin
    tag_d    = tag_q;
    weight_d = weight_q;
    case (op_i)
      hwpq_pkg::CELL_HOLD: begin
        tag_d    = tag_q;
        weight_d = weight_q;
      end
      hwpq_pkg::CELL_INS: begin
        // shift right from the insert point, new entry lands before equals
        if (left_ge_i) begin
          tag_d    = left_tag_i;
          weight_d = left_weight_i;
        end else if (!lt_o) begin
          tag_d    = key_tag_i;
          weight_d = key_weight_i;
        end
      end
      hwpq_pkg::CELL_POP: begin
        tag_d    = r1_tag_i;
        weight_d = r1_weight_i;
      end
      hwpq_pkg::CELL_MRG: begin
        // drop the two lightest and insert the key in the same move
        if (r1_ge_i) begin
          tag_d    = r1_tag_i;
          weight_d = r1_weight_i;
        end else if (r2_lt_i) begin
          tag_d    = r2_tag_i;
          weight_d = r2_weight_i;
        end else begin
          tag_d    = key_tag_i;
          weight_d = key_weight_i;
        end
      end
      default: begin
        tag_d    = tag_q;
        weight_d = weight_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    weight_q <= weight_d;
  end

  assign tag_o    = tag_q;
  assign weight_o = weight_q;

endmodule

@@ rtl/core/hwpq_chain.sv @@
module hwpq_chain #(
  parameter int unsigned QUEUE_DEPTH = hwpq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WEIGHT_BITS = hwpq_pkg::DEF_WEIGHT_BITS,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  hwpq_pkg::cell_op_e          op_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [hwpq_pkg::TAG_W-1:0]  key_tag_i,
  input  logic [WEIGHT_BITS-1:0]      key_weight_i,
  output logic [hwpq_pkg::TAG_W-1:0]  head0_tag_o,
  output logic [WEIGHT_BITS-1:0]      head0_weight_o,
  output logic [hwpq_pkg::TAG_W-1:0]  head1_tag_o,
  output logic [WEIGHT_BITS-1:0]      head1_weight_o
);

  logic [hwpq_pkg::TAG_W-1:0] tags    [QUEUE_DEPTH];
  logic [WEIGHT_BITS-1:0]     weights [QUEUE_DEPTH];
  logic                       ge      [QUEUE_DEPTH];
  logic                       lt      [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [hwpq_pkg::TAG_W-1:0] l_tag, r1_tag, r2_tag;
    logic [WEIGHT_BITS-1:0]     l_weight, r1_weight, r2_weight;
    logic                       l_ge, r1_ge, r2_lt;

    if (i == 0) begin : g_first
      assign l_tag    = '0;
      assign l_weight = '0;
      assign l_ge     = 1'b0;
    end else begin : g_left
      assign l_tag    = tags[i-1];
      assign l_weight = weights[i-1];
      assign l_ge     = ge[i-1];
    end

    if (i + 1 < QUEUE_DEPTH) begin : g_r1
      assign r1_tag    = tags[i+1];
      assign r1_weight = weights[i+1];
      // on a merge the head cell must not pick up the second child
      assign r1_ge     = (i == 0) ? 1'b0 : ge[i+1];
    end else begin : g_r1_end
      assign r1_tag    = '0;
      assign r1_weight = '0;
      assign r1_ge     = 1'b0;
    end

    if (i + 2 < QUEUE_DEPTH) begin : g_r2
      assign r2_tag    = tags[i+2];
      assign r2_weight = weights[i+2];
      assign r2_lt     = lt[i+2];
    end else begin : g_r2_end
      assign r2_tag    = '0;
      assign r2_weight = '0;
      assign r2_lt     = 1'b0;
    end

    hwpq_cell #(
      .IDX         (i),
      .WEIGHT_BITS (WEIGHT_BITS),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op_i),
      .count_i       (count_i),
      .key_tag_i     (key_tag_i),
      .key_weight_i  (key_weight_i),
      .left_tag_i    (l_tag),
      .left_weight_i (l_weight),
      .left_ge_i     (l_ge),
      .r1_tag_i      (r1_tag),
      .r1_weight_i   (r1_weight),
      .r1_ge_i       (r1_ge),
      .r2_tag_i      (r2_tag),
      .r2_weight_i   (r2_weight),
      .r2_lt_i       (r2_lt),
      .tag_o         (tags[i]),
      .weight_o      (weights[i]),
      .ge_o          (ge[i]),
      .lt_o          (lt[i])
    );
  end

  assign head0_tag_o    = tags[0];
  assign head0_weight_o = weights[0];
  assign head1_tag_o    = tags[1];
  assign head1_weight_o = weights[1];

endmodule

@@ sim/huffman_weight_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps

module huffman_weight_priority_queue_top_tb;
  import hwpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
  } node_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    first_tag;
    logic [WEIGHT_W-1:0] first_weight;
    logic [TAG_W-1:0]    second_tag;
    logic [WEIGHT_W-1:0] second_weight;
    logic [TAG_W-1:0]    merged_tag;
    logic [WEIGHT_W-1:0] merged_weight;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  hwpq_in_if  req_if ();
  hwpq_out_if res_if ();

  huffman_weight_priority_queue_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // shadow copy of the sorted queue, lightest first
  node_t          shadow_nodes[$];
  logic [TAG_W-1:0] shadow_next_tag;
  outcome_t       outcomes_due[$];
  outcome_t       seen_outcome;
  outcome_t       due_outcome;

  int sender_idle_pct;
  int receiver_stall_pct;
  int items_sent;
  int fail_count;
  int quiet_cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void place_shadow_node(input logic [TAG_W-1:0] tag,
                                            input logic [WEIGHT_W-1:0] weight);
    node_t n;
    int pos;
    n.tag = tag;
    n.weight = weight;
    pos = 0;
    // new node goes ahead of any node of equal weight
    while (pos < shadow_nodes.size() && shadow_nodes[pos].weight < weight) pos++;
    shadow_nodes.insert(pos, n);
  endfunction

  function automatic outcome_t predict_queue_outcome(input logic [KIND_W-1:0] op,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [WEIGHT_W-1:0] weight);
    outcome_t r;
    node_t lo;
    node_t hi;
    logic [WEIGHT_W:0] sum;
    r = '0;
    r.status = STAT_EMPTY;
    case (op)
      KIND_INSERT: begin
        if (weight == '0) begin
          r.status = STAT_ZERO;
        end else if (shadow_nodes.size() >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          place_shadow_node(tag, weight);
          r.status = STAT_OK;
        end
      end
      KIND_POP: begin
        if (shadow_nodes.size() != 0) begin
          lo = shadow_nodes.pop_front();
          r.status = STAT_OK;
          r.first_tag = lo.tag;
          r.first_weight = lo.weight;
        end
      end
      KIND_MERGE: begin
        if (shadow_nodes.size() == 1) begin
          // single root stays in the queue
          r.status = STAT_DONE;
          r.first_tag = shadow_nodes[0].tag;
          r.first_weight = shadow_nodes[0].weight;
        end else if (shadow_nodes.size() > 1) begin
          lo = shadow_nodes.pop_front();
          hi = shadow_nodes.pop_front();
          sum = {1'b0, lo.weight} + {1'b0, hi.weight};
          r.status = STAT_OK;
          r.first_tag = lo.tag;
          r.first_weight = lo.weight;
          r.second_tag = hi.tag;
          r.second_weight = hi.weight;
          r.merged_tag = shadow_next_tag;
          r.merged_weight = sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
          place_shadow_node(r.merged_tag, r.merged_weight);
          shadow_next_tag = shadow_next_tag + 1'b1;
        end
      end
      default: r.status = STAT_EMPTY;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string what, input outcome_t got, input outcome_t want);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: got st=%0d l=%h/%h r=%h/%h m=%h/%h, want st=%0d l=%h/%h r=%h/%h m=%h/%h",
               $realtime, what,
               got.status, got.first_tag, got.first_weight, got.second_tag,
               got.second_weight, got.merged_tag, got.merged_weight,
               want.status, want.first_tag, want.first_weight, want.second_tag,
               want.second_weight, want.merged_tag, want.merged_weight);
    end
  endtask

  // one request beat, with random sender gaps ahead of it
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [TAG_W-1:0] tag,
                              input logic [WEIGHT_W-1:0] weight);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    req_if.valid  <= 1'b1;
    req_if.kind   <= op;
    req_if.tag    <= tag;
    req_if.weight <= weight;
    do @(posedge clk_i); while (!req_if.ready);
    outcomes_due.push_back(predict_queue_outcome(op, tag, weight));
    if (op != KIND_BAD && !(op == KIND_INSERT && weight == '0)) items_sent++;
  endtask

  task automatic send_noise_free(input logic [KIND_W-1:0] op);
    send_request(op, TAG_W'($urandom), $urandom);
  endtask

  task automatic wait_results_drained;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(input int style);
    logic [WEIGHT_W-1:0] w;
    case (style)
      0:       w = $urandom_range(1, 8);
      1:       w = WEIGHT_MAX - $urandom_range(0, 1000);
      default: w = $urandom;
    endcase
    return (w == '0) ? 1 : w;
  endfunction

  task automatic test_empty_queue;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_noise_free(KIND_POP);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_BAD);
    send_request(KIND_INSERT, 9'h1ff, '0);
    wait_results_drained();
  endtask

  task automatic test_order_and_saturation;
    send_request(KIND_INSERT, 9'd0, 32'd1);
    send_request(KIND_INSERT, 9'h1ff, 32'd7);
    // equal weight lands ahead of the older entry
    send_request(KIND_INSERT, 9'd100, 32'd7);
    send_request(KIND_INSERT, 9'd255, WEIGHT_MAX);
    send_request(KIND_INSERT, 9'd256, WEIGHT_MAX - 1'b1);
    send_request(KIND_INSERT, 9'd42, '0);
    send_noise_free(KIND_BAD);
    send_noise_free(KIND_POP);
    send_noise_free(KIND_POP);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_POP);
    send_noise_free(KIND_POP);
    wait_results_drained();
  endtask

  task automatic test_fill_to_full;
    int style;
    sender_idle_pct = 37;
    receiver_stall_pct = 37;
    style = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i % 32 == 0) style = $urandom_range(0, 2);
      send_request(KIND_INSERT, TAG_W'($urandom), pick_weight(style));
    end
    send_request(KIND_INSERT, TAG_W'($urandom), pick_weight(2));
    send_request(KIND_INSERT, 9'h1ff, WEIGHT_MAX);
    send_request(KIND_INSERT, TAG_W'($urandom), '0);
    while (shadow_nodes.size() > 1) send_noise_free(KIND_MERGE);
    send_noise_free(KIND_MERGE);
    send_noise_free(KIND_POP);
    send_noise_free(KIND_MERGE);
    wait_results_drained();
  endtask

  task automatic send_noise_item;
    case ($urandom_range(0, 4))
      0: send_noise_free(KIND_POP);
      1: send_noise_free(KIND_BAD);
      2: send_request(KIND_INSERT, TAG_W'($urandom), '0);
      3: send_noise_free(KIND_MERGE);
      default: send_request(KIND_INSERT, TAG_W'($urandom), pick_weight(2));
    endcase
  endtask

  task automatic test_tree_builds;
    int build_idx;
    int leaves;
    int style;
    build_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      case ((build_idx / 3) % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
        default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
      leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      style = $urandom_range(0, 2);
      for (int i = 0; i < leaves; i++) begin
        send_request(KIND_INSERT,
                     ($urandom_range(0, 3) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 255)),
                     pick_weight(style));
        if ($urandom_range(0, 19) == 0) send_noise_item();
      end
      while (shadow_nodes.size() > 1) begin
        send_noise_free(KIND_MERGE);
        if ($urandom_range(0, 9) == 0) send_noise_item();
      end
      send_noise_free(KIND_MERGE);
      if ($urandom_range(0, 4) != 0) send_noise_free(KIND_POP);
      if ($urandom_range(0, 5) == 0) send_noise_item();
      build_idx++;
      if (build_idx % 8 == 0) wait_results_drained();
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen_outcome = {res_if.status, res_if.first_tag, res_if.first_weight,
                        res_if.second_tag, res_if.second_weight,
                        res_if.merged_tag, res_if.merged_weight};
        if (outcomes_due.size() == 0) begin
          note_failure("result beat with nothing pending", seen_outcome, '0);
        end else begin
          due_outcome = outcomes_due.pop_front();
          if (seen_outcome !== due_outcome) begin
            note_failure("result mismatch", seen_outcome, due_outcome);
          end
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[huffman_weight_priority_queue_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_INSERT;
    req_if.tag = '0;
    req_if.weight = '0;
    res_if.ready = 1'b0;
    shadow_next_tag = FIRST_INTERNAL_TAG;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    items_sent = 0;
    fail_count = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_order_and_saturation();
    test_fill_to_full();
    test_tree_builds();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[huffman_weight_priority_queue_top] OK");
    end else begin
      $display("[huffman_weight_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule
